// ===== src/aarpd_pkg.sv =====
// aarpd_pkg: types, codes and constants shared by the rectangle path detector
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package aarpd_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned TOL_W   = 16;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;

    // path command codes
    localparam logic [2:0] CMD_MOVETO = 3'd0;
    localparam logic [2:0] CMD_CLOSE  = 3'd1;
    localparam logic [2:0] CMD_LINETO = 3'd2;
    localparam logic [2:0] CMD_HLINE  = 3'd3;
    localparam logic [2:0] CMD_VLINE  = 3'd4;

    typedef enum logic [2:0] {
        DIR_LEFT  = 3'd0,
        DIR_RIGHT = 3'd1,
        DIR_UP    = 3'd2,
        DIR_DOWN  = 3'd3,
        DIR_NONE  = 3'd4
    } t_dir;

    typedef struct packed {
        logic [2:0]                cmd;
        logic                      relative;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic                      last;
    } t_in_item;

    typedef struct packed {
        logic                      is_rect;
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic [COORD_W-1:0]        box_width;
        logic [COORD_W-1:0]        box_height;
    } t_out_item;

    typedef struct packed {
        logic                      failed;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] cur_x;
        logic signed [COORD_W-1:0] cur_y;
        logic signed [COORD_W-1:0] box_min_x;
        logic signed [COORD_W-1:0] box_min_y;
        logic signed [COORD_W-1:0] box_max_x;
        logic signed [COORD_W-1:0] box_max_y;
        t_dir                      heading;
        logic [2:0]                corner_count;
        t_dir [3:0]                corner_dirs;
    } t_path_state;

    localparam t_path_state PATH_CLEAR = '{
        failed:       1'b0,
        start_x:      '0,
        start_y:      '0,
        cur_x:        '0,
        cur_y:        '0,
        box_min_x:    '0,
        box_min_y:    '0,
        box_max_x:    '0,
        box_max_y:    '0,
        heading:      DIR_NONE,
        corner_count: 3'd0,
        corner_dirs:  {DIR_NONE, DIR_NONE, DIR_NONE, DIR_NONE}
    };

endpackage

// ===== src/axis_aligned_rect_path_detector_core.sv =====
// axis_aligned_rect_path_detector_core: top level of the rectangle path detector
// depends on aarpd_pkg, aarpd_in_stage and aarpd_step
//
//   channel | direction | handshake             | payload
//   in      | input     | i_in_valid/o_in_stall | i_in_data   (t_in_item)
//   out     | output    | o_out_valid/i_out_stall | o_out_data (t_out_item)
//   cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_data (tolerance, 16 bit)
//
// one command per cycle while not stalled: input register, single-pass next-state
// logic, state and result registers; a verdict passes input and result registers
// synchronous active-low reset clears the path state and sets tolerance to 66
// only a last command waits on a stalled output; other commands keep flowing
`timescale 1ns / 1ps

module axis_aligned_rect_path_detector_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  aarpd_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output aarpd_pkg::t_out_item o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [15:0]          i_cfg_data
);
    import aarpd_pkg::*;

    logic [TOL_W-1:0] r_tolerance;
    t_path_state      r_state;
    t_path_state      n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    t_out_item        r_out_data;
    t_out_item        w_result;
    logic             w_cmd_valid;
    t_in_item         w_cmd;
    logic             w_out_free;
    logic             w_advance;

    assign o_cfg_ready = 1'b1;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_advance  = w_cmd_valid && (!w_cmd.last || w_out_free);

    aarpd_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_item    (i_in_data),
        .i_advance (w_advance),
        .o_valid   (w_cmd_valid),
        .o_item    (w_cmd)
    );

    aarpd_step u_step (
        .i_state  (r_state),
        .i_item   (w_cmd),
        .i_tol    (r_tolerance),
        .o_state  (n_state),
        .o_result (w_result)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_advance && w_cmd.last) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= TOL_RESET;
            r_state     <= PATH_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_tolerance <= i_cfg_data;
            end
            if (w_advance) begin
                r_state <= n_state;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_cmd.last) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // no more than four corners are ever recorded
    a_corner_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.corner_count <= 3'd4)
        else $error("corner count above four");

    // a last transaction leaves the path state cleared
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_cmd.last) |=> (r_state == PATH_CLEAR))
        else $error("path state not cleared after last command");

    // a result appears only after a last command was processed
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_valid) && $past(i_rst_n)) |-> $past(w_advance && w_cmd.last))
        else $error("result without a last command");

    // commands that produce no result never wait on the output side
    a_no_needless_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd_valid && !w_cmd.last) |-> !o_in_stall)
        else $error("non-last command stalled");

endmodule

// ===== src/aarpd_in_stage.sv =====
// aarpd_in_stage: input register holding one accepted path command
// depends on aarpd_pkg for the input item type
`timescale 1ns / 1ps

module aarpd_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  aarpd_pkg::t_in_item i_item,
    input  logic                i_advance,
    output logic                o_valid,
    output aarpd_pkg::t_in_item o_item
);
    import aarpd_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     w_load;

    // the register takes a new command when it is empty or its current one moves on
    assign o_stall = r_valid && !i_advance;
    assign w_load  = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== src/aarpd_step.sv =====
// aarpd_step: next path state and verdict for one command, combinational
// depends on aarpd_pkg for item, state and direction types
`timescale 1ns / 1ps

module aarpd_step (
    input  aarpd_pkg::t_path_state i_state,
    input  aarpd_pkg::t_in_item    i_item,
    input  logic [15:0]            i_tol,
    output aarpd_pkg::t_path_state o_state,
    output aarpd_pkg::t_out_item   o_result
);
    import aarpd_pkg::*;

    function automatic t_dir opposite(input t_dir d);
        t_dir r;
        case (d)
            DIR_LEFT:  r = DIR_RIGHT;
            DIR_RIGHT: r = DIR_LEFT;
            DIR_UP:    r = DIR_DOWN;
            DIR_DOWN:  r = DIR_UP;
            default:   r = DIR_NONE;
        endcase
        return r;
    endfunction

    function automatic logic signed [33:0] sext(input logic signed [31:0] v);
        return {{2{v[31]}}, v};
    endfunction

    // both components strictly inside the tolerance
    function automatic logic near_eq(input logic signed [31:0] ax,
                                     input logic signed [31:0] ay,
                                     input logic signed [31:0] bx,
                                     input logic signed [31:0] by,
                                     input logic signed [33:0] tol);
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        dx = sext(bx) - sext(ax);
        dy = sext(by) - sext(ay);
        return (dx < tol) && (dx > -tol) && (dy < tol) && (dy > -tol);
    endfunction

    function automatic logic four_corners(input t_path_state s);
        return (s.corner_count == 3'd4) &&
               (s.corner_dirs[0] == opposite(s.corner_dirs[2])) &&
               (s.corner_dirs[1] == opposite(s.corner_dirs[3]));
    endfunction

    logic signed [33:0] w_tol;
    logic signed [32:0] w_sum_x;
    logic signed [32:0] w_sum_y;
    logic               w_ovf_x;
    logic               w_ovf_y;
    logic               w_uses_x;
    logic               w_uses_y;
    logic signed [31:0] w_tgt_x;
    logic signed [31:0] w_tgt_y;
    logic               w_ovf;
    logic signed [31:0] w_to_x;
    logic signed [31:0] w_to_y;
    logic signed [33:0] w_dx;
    logic signed [33:0] w_dy;
    logic               w_nx;
    logic               w_ny;
    t_dir               w_dir;
    logic               w_turn;
    logic               w_edge_fail;
    t_path_state        w_edge;
    t_path_state        w_new;
    logic               w_fail;
    t_path_state        w_proc;
    logic               w_ok;

    assign w_tol = $signed({18'd0, i_tol});

    // relative targets, overflow of the signed 32 bit range
    assign w_sum_x = {i_state.cur_x[31], i_state.cur_x} + {i_item.coord_x[31], i_item.coord_x};
    assign w_sum_y = {i_state.cur_y[31], i_state.cur_y} + {i_item.coord_y[31], i_item.coord_y};
    assign w_ovf_x = w_sum_x[32] ^ w_sum_x[31];
    assign w_ovf_y = w_sum_y[32] ^ w_sum_y[31];

    assign w_uses_x = (i_item.cmd == CMD_MOVETO) || (i_item.cmd == CMD_LINETO) ||
                      (i_item.cmd == CMD_HLINE);
    assign w_uses_y = (i_item.cmd == CMD_MOVETO) || (i_item.cmd == CMD_LINETO) ||
                      (i_item.cmd == CMD_VLINE);

    assign w_tgt_x = !w_uses_x ? i_state.cur_x :
                     (i_item.relative ? w_sum_x[31:0] : i_item.coord_x);
    assign w_tgt_y = !w_uses_y ? i_state.cur_y :
                     (i_item.relative ? w_sum_y[31:0] : i_item.coord_y);
    assign w_ovf   = i_item.relative && ((w_uses_x && w_ovf_x) || (w_uses_y && w_ovf_y));

    // one edge unit: closepath runs back to the subpath start
    assign w_to_x = (i_item.cmd == CMD_CLOSE) ? i_state.start_x : w_tgt_x;
    assign w_to_y = (i_item.cmd == CMD_CLOSE) ? i_state.start_y : w_tgt_y;
    assign w_dx   = sext(w_to_x) - sext(i_state.cur_x);
    assign w_dy   = sext(w_to_y) - sext(i_state.cur_y);
    assign w_nx   = (w_dx > w_tol) || (w_dx < -w_tol);
    assign w_ny   = (w_dy > w_tol) || (w_dy < -w_tol);

    always_comb begin
        if (w_nx) begin
            w_dir = (w_dx > 34'sd0) ? DIR_RIGHT : DIR_LEFT;
        end else begin
            w_dir = (w_dy > 34'sd0) ? DIR_DOWN : DIR_UP;
        end
    end

    assign w_turn      = (w_nx ^ w_ny) && (w_dir != i_state.heading);
    assign w_edge_fail = (w_nx && w_ny) ||
                         (w_turn && ((i_state.corner_count >= 3'd4) ||
                                     (w_dir == opposite(i_state.heading))));

    always_comb begin
        w_edge = i_state;
        if (w_nx ^ w_ny) begin
            if (w_turn) begin
                w_edge.corner_dirs[i_state.corner_count[1:0]] = w_dir;
                w_edge.corner_count = i_state.corner_count + 3'd1;
                w_edge.heading      = w_dir;
            end
            if (w_to_x < i_state.box_min_x) w_edge.box_min_x = w_to_x;
            if (w_to_y < i_state.box_min_y) w_edge.box_min_y = w_to_y;
            if (w_to_x > i_state.box_max_x) w_edge.box_max_x = w_to_x;
            if (w_to_y > i_state.box_max_y) w_edge.box_max_y = w_to_y;
        end
    end

    always_comb begin
        w_new  = w_edge;
        w_fail = 1'b0;
        case (i_item.cmd)
            CMD_MOVETO: begin
                w_fail = (i_state.corner_count != 3'd0) || w_ovf ||
                         !near_eq(i_state.start_x, i_state.start_y,
                                  i_state.cur_x, i_state.cur_y, w_tol);
                w_new           = i_state;
                w_new.start_x   = w_tgt_x;
                w_new.start_y   = w_tgt_y;
                w_new.cur_x     = w_tgt_x;
                w_new.cur_y     = w_tgt_y;
                w_new.box_min_x = w_tgt_x;
                w_new.box_max_x = w_tgt_x;
                w_new.box_min_y = w_tgt_y;
                w_new.box_max_y = w_tgt_y;
            end
            CMD_CLOSE: begin
                w_fail        = w_edge_fail || !four_corners(w_edge);
                w_new.start_x = i_state.cur_x;
                w_new.start_y = i_state.cur_y;
            end
            CMD_LINETO, CMD_HLINE, CMD_VLINE: begin
                w_fail      = w_ovf || w_edge_fail;
                w_new.cur_x = w_tgt_x;
                w_new.cur_y = w_tgt_y;
            end
            default: begin
                w_fail = 1'b1;
            end
        endcase
    end

    // once failed the path ignores commands until its last one
    always_comb begin
        if (i_state.failed) begin
            w_proc = i_state;
        end else if (w_fail) begin
            w_proc        = i_state;
            w_proc.failed = 1'b1;
        end else begin
            w_proc = w_new;
        end
    end

    assign w_ok = !w_proc.failed && four_corners(w_proc) &&
                  near_eq(w_proc.start_x, w_proc.start_y, w_proc.cur_x, w_proc.cur_y, w_tol);

    always_comb begin
        o_result = '0;
        if (w_ok) begin
            o_result.is_rect    = 1'b1;
            o_result.min_x      = w_proc.box_min_x;
            o_result.min_y      = w_proc.box_min_y;
            o_result.box_width  = w_proc.box_max_x - w_proc.box_min_x;
            o_result.box_height = w_proc.box_max_y - w_proc.box_min_y;
        end
    end

    assign o_state = i_item.last ? PATH_CLEAR : w_proc;

endmodule

// ===== dv/aarpd_tb_pkg.sv =====
// aarpd_tb_pkg: verdict scoreboard for the rectangle path detector testbench
// predicts each path verdict from accepted commands; depends on aarpd_pkg
`timescale 1ns / 1ps

package aarpd_tb_pkg;

    import aarpd_pkg::*;

    typedef logic signed [COORD_W-1:0] t_coord;

    localparam longint COORD_MAX_L = 64'sd2147483647;
    localparam longint COORD_MIN_L = -64'sd2147483648;

    class rect_verdict_scoreboard;

        longint    tol;
        bit        failed;
        t_coord    start_x, start_y, cur_x, cur_y;
        t_coord    lo_x, lo_y, hi_x, hi_y;
        t_dir      heading;
        int        corners;
        t_dir      corner_dirs [4];
        t_out_item verdicts_due [$];
        int        mismatches;

        function new();
            tol = longint'(TOL_RESET);
            mismatches = 0;
            clear_path();
        endfunction

        function void set_tolerance(input logic [TOL_W-1:0] value);
            tol = longint'(value);
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction

        function void clear_path();
            failed = 1'b0;
            start_x = '0; start_y = '0;
            cur_x = '0; cur_y = '0;
            lo_x = '0; lo_y = '0; hi_x = '0; hi_y = '0;
            heading = DIR_NONE;
            corners = 0;
            foreach (corner_dirs[i]) corner_dirs[i] = DIR_NONE;
        endfunction

        function t_dir opposite(input t_dir d);
            case (d)
                DIR_LEFT:  return DIR_RIGHT;
                DIR_RIGHT: return DIR_LEFT;
                DIR_UP:    return DIR_DOWN;
                DIR_DOWN:  return DIR_UP;
                default:   return DIR_NONE;
            endcase
        endfunction

        function longint magnitude(input longint d);
            return (d < 0) ? -d : d;
        endfunction

        function bit near_eq(input t_coord ax, input t_coord ay,
                             input t_coord bx, input t_coord by);
            longint dx, dy;
            dx = longint'(bx) - longint'(ax);
            dy = longint'(by) - longint'(ay);
            return magnitude(dx) < tol && magnitude(dy) < tol;
        endfunction

        function bit four_corners();
            if (corners != 4) return 1'b0;
            return corner_dirs[0] == opposite(corner_dirs[2]) &&
                   corner_dirs[1] == opposite(corner_dirs[3]);
        endfunction

        // an edge within tolerance on both axes is ignored altogether
        function bit edge_ok(input t_coord fx, input t_coord fy,
                             input t_coord tx, input t_coord ty);
            longint dx, dy;
            bit     nx, ny;
            t_dir   d;
            dx = longint'(tx) - longint'(fx);
            dy = longint'(ty) - longint'(fy);
            nx = magnitude(dx) > tol;
            ny = magnitude(dy) > tol;
            if (nx && ny) return 1'b0;
            if (!nx && !ny) return 1'b1;
            if (nx) d = (dx > 0) ? DIR_RIGHT : DIR_LEFT;
            else d = (dy > 0) ? DIR_DOWN : DIR_UP;
            if (d != heading) begin
                if (corners >= 4) return 1'b0;
                if (d == opposite(heading)) return 1'b0;
                corner_dirs[corners] = d;
                corners++;
                heading = d;
            end
            if (tx < lo_x) lo_x = tx;
            if (ty < lo_y) lo_y = ty;
            if (tx > hi_x) hi_x = tx;
            if (ty > hi_y) hi_y = ty;
            return 1'b1;
        endfunction

        function bit add_rel(input t_coord base, input longint off, output t_coord res);
            longint s;
            s = longint'(base) + off;
            res = s[COORD_W-1:0];
            return !(s > COORD_MAX_L || s < COORD_MIN_L);
        endfunction

        function bit apply_command(input t_in_item it);
            t_coord tx, ty;
            longint ox, oy;
            ox = longint'(it.coord_x);
            oy = longint'(it.coord_y);
            case (it.cmd)
                CMD_MOVETO: begin
                    if (corners != 0) return 1'b0;
                    if (!near_eq(start_x, start_y, cur_x, cur_y)) return 1'b0;
                    if (it.relative) begin
                        if (!add_rel(cur_x, ox, tx)) return 1'b0;
                        if (!add_rel(cur_y, oy, ty)) return 1'b0;
                    end else begin
                        tx = it.coord_x;
                        ty = it.coord_y;
                    end
                    start_x = tx; start_y = ty;
                    cur_x = tx; cur_y = ty;
                    lo_x = tx; hi_x = tx;
                    lo_y = ty; hi_y = ty;
                    return 1'b1;
                end
                CMD_CLOSE: begin
                    if (!edge_ok(cur_x, cur_y, start_x, start_y)) return 1'b0;
                    if (!four_corners()) return 1'b0;
                    start_x = cur_x;
                    start_y = cur_y;
                    return 1'b1;
                end
                CMD_LINETO, CMD_HLINE, CMD_VLINE: begin
                    tx = cur_x;
                    ty = cur_y;
                    if (it.cmd != CMD_VLINE) begin
                        if (it.relative) begin
                            if (!add_rel(cur_x, ox, tx)) return 1'b0;
                        end else begin
                            tx = it.coord_x;
                        end
                    end
                    if (it.cmd != CMD_HLINE) begin
                        if (it.relative) begin
                            if (!add_rel(cur_y, oy, ty)) return 1'b0;
                        end else begin
                            ty = it.coord_y;
                        end
                    end
                    if (!edge_ok(cur_x, cur_y, tx, ty)) return 1'b0;
                    cur_x = tx;
                    cur_y = ty;
                    return 1'b1;
                end
                default: return 1'b0;
            endcase
        endfunction

        function void note_command(input t_in_item it);
            t_out_item v;
            if (!failed && !apply_command(it)) failed = 1'b1;
            if (!it.last) return;
            v = '0;
            if (!failed && near_eq(start_x, start_y, cur_x, cur_y) && four_corners()) begin
                v.is_rect = 1'b1;
                v.min_x = lo_x;
                v.min_y = lo_y;
                v.box_width = hi_x - lo_x;
                v.box_height = hi_y - lo_y;
            end
            verdicts_due.push_back(v);
            clear_path();
        endfunction

        function void check_verdict(input t_out_item got);
            t_out_item want;
            if (verdicts_due.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected verdict: rect=%0b x=%0d y=%0d w=%0d h=%0d",
                             got.is_rect, got.min_x, got.min_y, got.box_width,
                             got.box_height);
                mismatches++;
                return;
            end
            want = verdicts_due.pop_front();
            if (got.is_rect !== want.is_rect || got.min_x !== want.min_x ||
                got.min_y !== want.min_y || got.box_width !== want.box_width ||
                got.box_height !== want.box_height) begin
                if (mismatches < 10) begin
                    $display("verdict mismatch: expected rect=%0b x=%0d y=%0d w=%0d h=%0d",
                             want.is_rect, want.min_x, want.min_y, want.box_width,
                             want.box_height);
                    $display("                  actual   rect=%0b x=%0d y=%0d w=%0d h=%0d",
                             got.is_rect, got.min_x, got.min_y, got.box_width,
                             got.box_height);
                end
                mismatches++;
            end
        endfunction

    endclass

endpackage

// ===== dv/tb_top.sv =====
// tb_top: self-checking testbench for axis_aligned_rect_path_detector_core
// drives directed and random path commands, checks verdicts; needs aarpd_tb_pkg
`timescale 1ns / 1ps

module tb_top;

    import aarpd_pkg::*;
    import aarpd_tb_pkg::*;

    localparam int RESET_CYCLES    = 7;
    localparam int PHASE_ITEMS     = 150;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int UNIT            = 65536;
    localparam int COORD_MAX_I     = 2147483647;
    localparam int COORD_MIN_I     = -2147483647 - 1;

    // codes the block treats as unsupported commands
    localparam logic [2:0] CMD_OTHER  = 3'd5;
    localparam logic [2:0] CMD_RSVD_6 = 3'd6;
    localparam logic [2:0] CMD_RSVD_7 = 3'd7;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    t_in_item   in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_item  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [15:0] cfg_data = '0;

    logic       hold_off_req = 1'b0;
    logic       calm = 1'b0;
    int         quiet_cycles = 0;
    int         sent = 0;
    int         pen_x, pen_y;
    t_in_item   path_q [$];

    rect_verdict_scoreboard verdicts;

    axis_aligned_rect_path_detector_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_valid && !out_stall) verdicts.check_verdict(out_data);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial begin : receiver
        bit pressure_done;
        pressure_done = 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off_req && !pressure_done) begin
                pressure_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            out_stall <= !calm && ($urandom_range(0, 99) < 20);
        end
    end

    function automatic t_in_item make_cmd(input logic [2:0] cmd, input logic rel,
                                          input int x, input int y);
        t_in_item it;
        it = '0;
        it.cmd = cmd;
        it.relative = rel;
        it.coord_x = x;
        it.coord_y = y;
        return it;
    endfunction

    function automatic t_in_item random_cmd();
        t_in_item it;
        it = '0;
        it.cmd = 3'($urandom_range(0, 7));
        it.relative = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1)) begin
            it.coord_x = $urandom;
            it.coord_y = $urandom;
        end else begin
            it.coord_x = $urandom_range(0, 1 << 18) - (1 << 17);
            it.coord_y = $urandom_range(0, 1 << 18) - (1 << 17);
        end
        return it;
    endfunction

    function automatic int pick_span(input int tol);
        case ($urandom_range(0, 3))
            0:       return tol + 1;
            1:       return tol + 1 + $urandom_range(0, 255);
            2:       return tol + 1 + $urandom_range(0, 1 << 20);
            default: return tol + 1 + $urandom_range(0, 1 << 28);
        endcase
    endfunction

    task automatic send_command(input t_in_item it);
        while (!calm && $urandom_range(0, 99) < 20) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        verdicts.note_command(it);
        sent++;
    endtask

    task automatic send_path();
        path_q[path_q.size()-1].last = 1'b1;
        foreach (path_q[i]) send_command(path_q[i]);
        path_q.delete();
    endtask

    // called at the acceptance edge of the last command of a phase
    task automatic drain_verdicts();
        in_valid <= 1'b0;
        while (verdicts.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tolerance(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        verdicts.set_tolerance(value);
    endtask

    // one edge from the pen to the target, as lineto, horizontal or vertical
    task automatic add_edge(input int tx, input int ty);
        logic       rel;
        logic [2:0] cmd;
        int         x, y;
        rel = 1'($urandom_range(0, 1));
        if (ty == pen_y && $urandom_range(0, 2) != 0) cmd = CMD_HLINE;
        else if (tx == pen_x && $urandom_range(0, 2) != 0) cmd = CMD_VLINE;
        else cmd = CMD_LINETO;
        x = rel ? tx - pen_x : tx;
        y = rel ? ty - pen_y : ty;
        if (cmd == CMD_HLINE) y = $urandom;
        if (cmd == CMD_VLINE) x = $urandom;
        path_q.push_back(make_cmd(cmd, rel, x, y));
        pen_x = tx;
        pen_y = ty;
    endtask

    task automatic add_moveto(input int tx, input int ty);
        logic rel;
        rel = 1'($urandom_range(0, 1));
        path_q.push_back(make_cmd(CMD_MOVETO, rel, rel ? tx - pen_x : tx,
                                  rel ? ty - pen_y : ty));
        pen_x = tx;
        pen_y = ty;
    endtask

    task automatic add_rect_path(input int tol);
        int px [4];
        int py [4];
        int sw, sh, jx, jy;
        pen_x = 0;
        pen_y = 0;
        px[0] = $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000;
        py[0] = $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000;
        sw = pick_span(tol);
        sh = pick_span(tol);
        if ($urandom_range(0, 1)) sw = -sw;
        if ($urandom_range(0, 1)) sh = -sh;
        if ($urandom_range(0, 1)) begin
            px[1] = px[0] + sw; py[1] = py[0];
            px[2] = px[0] + sw; py[2] = py[0] + sh;
            px[3] = px[0];      py[3] = py[0] + sh;
        end else begin
            px[1] = px[0];      py[1] = py[0] + sh;
            px[2] = px[0] + sw; py[2] = py[0] + sh;
            px[3] = px[0] + sw; py[3] = py[0];
        end
        if ($urandom_range(0, 4) == 0)
            add_moveto($urandom_range(0, 1 << 24), $urandom_range(0, 1 << 24));
        add_moveto(px[0], py[0]);
        for (int i = 1; i < 4; i++) begin
            // collinear split, same heading throughout
            if ($urandom_range(0, 3) == 0)
                add_edge(pen_x + (px[i] - pen_x) / 2, pen_y + (py[i] - pen_y) / 2);
            add_edge(px[i], py[i]);
        end
        case ($urandom_range(0, 2))
            0: begin
                // return to the start within or just at the tolerance
                jx = $urandom_range(0, tol);
                jy = $urandom_range(0, tol);
                add_edge(px[0] + jx, py[0] + jy);
            end
            1: path_q.push_back(make_cmd(CMD_CLOSE, 1'($urandom_range(0, 1)),
                                         $urandom, $urandom));
            default: begin
                add_edge(px[0], py[0]);
                path_q.push_back(make_cmd(CMD_CLOSE, 1'($urandom_range(0, 1)),
                                          $urandom, $urandom));
            end
        endcase
    endtask

    task automatic corrupt_path();
        int pos;
        pos = $urandom_range(0, path_q.size() - 1);
        case ($urandom_range(0, 3))
            0: path_q[pos] = random_cmd();
            1: path_q.insert(pos, make_cmd(CMD_LINETO, 1'b1, $urandom_range(1, 1 << 20),
                                           $urandom_range(1, 1 << 20)));
            2: if (path_q.size() > 1) path_q.delete(pos);
            default: path_q.push_back(random_cmd());
        endcase
    endtask

    task automatic run_random(input int tol, input int budget);
        int stop, pick, n;
        stop = sent + budget;
        while (sent < stop) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                n = $urandom_range(1, 6);
                repeat (n) path_q.push_back(random_cmd());
            end else begin
                add_rect_path(tol);
                if (pick < 35) corrupt_path();
            end
            send_path();
        end
    endtask

    task automatic run_directed();
        // closed rectangle, absolute coordinates
        path_q.push_back(make_cmd(CMD_MOVETO, 1'b0, UNIT, 2 * UNIT));
        path_q.push_back(make_cmd(CMD_HLINE, 1'b0, 5 * UNIT, 32'h5A5A_5A5A));
        path_q.push_back(make_cmd(CMD_VLINE, 1'b0, 32'hA5A5_A5A5, 7 * UNIT));
        path_q.push_back(make_cmd(CMD_HLINE, 1'b0, UNIT, 0));
        path_q.push_back(make_cmd(CMD_CLOSE, 1'b0, $urandom, $urandom));
        send_path();
        // relative edges, unused coordinates full of junk
        path_q.push_back(make_cmd(CMD_MOVETO, 1'b1, -3 * UNIT, -UNIT));
        path_q.push_back(make_cmd(CMD_HLINE, 1'b1, 4 * UNIT, 32'hFFFF_FFFF));
        path_q.push_back(make_cmd(CMD_VLINE, 1'b1, 32'h7FFF_FFFF, 2 * UNIT));
        path_q.push_back(make_cmd(CMD_LINETO, 1'b1, -4 * UNIT, 0));
        path_q.push_back(make_cmd(CMD_LINETO, 1'b1, 0, -2 * UNIT));
        send_path();
        // full coordinate range
        path_q.push_back(make_cmd(CMD_MOVETO, 1'b0, COORD_MIN_I, COORD_MIN_I));
        path_q.push_back(make_cmd(CMD_HLINE, 1'b0, COORD_MAX_I, 0));
        path_q.push_back(make_cmd(CMD_VLINE, 1'b0, 0, COORD_MAX_I));
        path_q.push_back(make_cmd(CMD_HLINE, 1'b0, COORD_MIN_I, 0));
        path_q.push_back(make_cmd(CMD_VLINE, 1'b0, 0, COORD_MIN_I));
        send_path();
        // edge exactly at the tolerance, then an unsupported command
        path_q.push_back(make_cmd(CMD_MOVETO, 1'b0, 0, 0));
        path_q.push_back(make_cmd(CMD_LINETO, 1'b0, int'(TOL_RESET), 40));
        path_q.push_back(make_cmd(CMD_OTHER, 1'b0, 0, 0));
        send_path();
        path_q.push_back(make_cmd(CMD_RSVD_6, 1'b0, 0, 0));
        send_path();
        path_q.push_back(make_cmd(CMD_RSVD_7, 1'b1, -1, -1));
        send_path();
        // relative step past the bottom of the range
        path_q.push_back(make_cmd(CMD_MOVETO, 1'b0, COORD_MAX_I, COORD_MIN_I));
        path_q.push_back(make_cmd(CMD_VLINE, 1'b1, 12345, -1));
        send_path();
        // reversal on one axis
        path_q.push_back(make_cmd(CMD_MOVETO, 1'b0, 0, 0));
        path_q.push_back(make_cmd(CMD_HLINE, 1'b0, UNIT, 0));
        path_q.push_back(make_cmd(CMD_HLINE, 1'b0, -UNIT, 0));
        send_path();
    endtask

    initial begin
        logic [15:0] tol_mid;
        verdicts = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random(int'(TOL_RESET), PHASE_ITEMS);
        drain_verdicts();
        write_tolerance(16'h0000);
        // long output hold-off while commands keep coming
        hold_off_req <= 1'b1;
        run_random(0, PHASE_ITEMS);
        drain_verdicts();
        write_tolerance(16'hFFFF);
        calm <= 1'b1;
        run_random(65535, PHASE_ITEMS);
        calm <= 1'b0;
        drain_verdicts();
        tol_mid = 16'($urandom_range(1, 16'hFFFE));
        write_tolerance(tol_mid);
        run_random(int'(tol_mid), PHASE_ITEMS);
        drain_verdicts();
        if (verdicts.mismatches == 0 && verdicts.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
src/aarpd_pkg.sv
src/aarpd_in_stage.sv
src/aarpd_step.sv
src/axis_aligned_rect_path_detector_core.sv
dv/aarpd_tb_pkg.sv
dv/tb_top.sv
